FILE: sv/kwtm_pkg.sv
// Package: shared constants and types for the k-way tournament merger.
`timescale 1ns / 1ps
package kwtm_pkg;

    localparam int MAX_WAYS = 8;
    localparam int WAY_W    = $clog2(MAX_WAYS);
    localparam int LEAVES   = 1 << WAY_W;
    localparam int NODES    = 2 * LEAVES - 1;
    localparam int KEY_W    = 32;
    localparam int SER_W    = 32;
    localparam int WCNT_W   = 4;

    localparam logic CMD_RECORD  = 1'b0;
    localparam logic CMD_EXHAUST = 1'b1;

    localparam logic [WCNT_W-1:0] WAY_COUNT_RESET = WCNT_W'(2);

    typedef struct packed {
        logic             found;
        logic [WAY_W-1:0] best;
    } sel_t;

endpackage

FILE: sv/kwtm_select.sv
// Winner tree: picks the smallest valid record by key, serial, then lower way.
`timescale 1ns / 1ps
module kwtm_select
    import kwtm_pkg::*;
(
    input  logic [MAX_WAYS-1:0]    cand_valid,
    input  logic signed [KEY_W-1:0] cand_key [MAX_WAYS],
    input  logic [SER_W-1:0]       cand_serial [MAX_WAYS],
    output sel_t                   sel
);

    logic                    nd_valid  [NODES];
    logic signed [KEY_W-1:0] nd_key    [NODES];
    logic [SER_W-1:0]        nd_serial [NODES];
    logic [WAY_W-1:0]        nd_way    [NODES];

    always_comb
    begin
        for (int j = NODES - 1; j >= 0; j--)
        begin
            if (j >= LEAVES - 1)
            begin
                if (j - (LEAVES - 1) < MAX_WAYS)
                begin
                    nd_valid[j]  = cand_valid[j - (LEAVES - 1)];
                    nd_key[j]    = cand_key[j - (LEAVES - 1)];
                    nd_serial[j] = cand_serial[j - (LEAVES - 1)];
                end
                else
                begin
                    nd_valid[j]  = 1'b0;
                    nd_key[j]    = '0;
                    nd_serial[j] = '0;
                end
                nd_way[j] = WAY_W'(j - (LEAVES - 1));
            end
            else if (nd_valid[2*j+2] && (!nd_valid[2*j+1] ||
                     (nd_key[2*j+2] < nd_key[2*j+1]) ||
                     ((nd_key[2*j+2] == nd_key[2*j+1]) &&
                      (nd_serial[2*j+2] < nd_serial[2*j+1]))))
            begin
                nd_valid[j]  = 1'b1;
                nd_key[j]    = nd_key[2*j+2];
                nd_serial[j] = nd_serial[2*j+2];
                nd_way[j]    = nd_way[2*j+2];
            end
            else
            begin
                nd_valid[j]  = nd_valid[2*j+1];
                nd_key[j]    = nd_key[2*j+1];
                nd_serial[j] = nd_serial[2*j+1];
                nd_way[j]    = nd_way[2*j+1];
            end
        end
    end

    assign sel.found = nd_valid[0];
    assign sel.best  = nd_way[0];

endmodule

FILE: sv/kwtm_top.sv
// Result register stage with the valid/ready output handshake.
`timescale 1ns / 1ps
module kwtm_out_stage
    import kwtm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic                    emit,
    input  logic signed [KEY_W-1:0] res_key,
    input  logic [SER_W-1:0]        res_serial,
    input  logic [WAY_W-1:0]        res_way,
    input  logic                    res_done,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [KEY_W-1:0] out_key,
    output logic [SER_W-1:0]        out_serial,
    output logic [2:0]              out_way,
    output logic                    done_res
);

    logic                    valid_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [SER_W-1:0]        serial_reg;
    logic [WAY_W-1:0]        way_reg;
    logic                    done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= emit;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            key_reg    <= res_key;
            serial_reg <= res_serial;
            way_reg    <= res_way;
            done_reg   <= res_done;
        end
    end

    assign out_valid  = valid_reg;
    assign out_key    = key_reg;
    assign out_serial = serial_reg;
    assign out_way    = 3'(way_reg);
    assign done_res   = done_reg;

endmodule

FILE: sv/kway_tournament_merger_top.sv
// Top level: k-way merge of sorted runs with a winner-tree selection.
// Path: an accepted input is held in the input register; the tree and state update
// lie between it and the result register, which loads only when the output slot frees.
// Throughput: one item per cycle unless the output stalls; the winner tree is combinational.
// Reset: asynchronous, active low; all ways await a record, way_count is 2.
`timescale 1ns / 1ps
module kway_tournament_merger_top
    import kwtm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wen,
    input  logic [WCNT_W-1:0]       cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic [2:0]              way,
    input  logic signed [KEY_W-1:0] key,
    input  logic [SER_W-1:0]        serial,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [KEY_W-1:0] out_key,
    output logic [SER_W-1:0]        out_serial,
    output logic [2:0]              out_way,
    output logic                    done_res
);

    logic [WCNT_W-1:0] way_count_reg;

    logic                    in_valid_reg;
    logic                    cmd_reg;
    logic [WAY_W-1:0]        way_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [SER_W-1:0]        serial_reg;

    logic signed [KEY_W-1:0] held_key_reg    [MAX_WAYS];
    logic [SER_W-1:0]        held_serial_reg [MAX_WAYS];
    logic [MAX_WAYS-1:0]     holding_reg;
    logic [MAX_WAYS-1:0]     awaiting_reg;
    logic [MAX_WAYS-1:0]     holding_next;
    logic [MAX_WAYS-1:0]     awaiting_next;

    logic [WCNT_W-1:0]       n_act;
    logic [MAX_WAYS-1:0]     act;
    logic                    take;
    logic                    wr_rec;
    logic                    any_wait;
    logic                    emit;
    logic                    proc_en;
    logic signed [KEY_W-1:0] cand_key    [MAX_WAYS];
    logic [SER_W-1:0]        cand_serial [MAX_WAYS];
    sel_t                    sel;
    logic signed [KEY_W-1:0] res_key;
    logic [SER_W-1:0]        res_serial;
    logic [WAY_W-1:0]        res_way;
    logic                    res_done;

    // out_valid is read back as the output slot's occupancy
    assign proc_en  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || proc_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_count_reg <= WAY_COUNT_RESET;
        end
        else if (cfg_wen)
        begin
            way_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg    <= command;
            way_reg    <= WAY_W'(way);
            key_reg    <= key;
            serial_reg <= serial;
        end
    end

    assign n_act = (way_count_reg > WCNT_W'(MAX_WAYS)) ? WCNT_W'(MAX_WAYS) : way_count_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            act[i] = (WCNT_W'(i) < n_act);
        end
    end

    assign take   = act[way_reg] && awaiting_reg[way_reg];
    assign wr_rec = take && (cmd_reg == CMD_RECORD);

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (wr_rec && (way_reg == WAY_W'(i)))
            begin
                cand_key[i]    = key_reg;
                cand_serial[i] = serial_reg;
            end
            else
            begin
                cand_key[i]    = held_key_reg[i];
                cand_serial[i] = held_serial_reg[i];
            end
        end
    end

    logic [MAX_WAYS-1:0] hold_upd;
    logic [MAX_WAYS-1:0] await_upd;

    always_comb
    begin
        hold_upd  = holding_reg;
        await_upd = awaiting_reg;
        if (take)
        begin
            await_upd[way_reg] = 1'b0;
            hold_upd[way_reg]  = (cmd_reg == CMD_RECORD);
        end
    end

    assign any_wait = |(await_upd & act);

    kwtm_select u_select (
        .cand_valid  (hold_upd & act),
        .cand_key    (cand_key),
        .cand_serial (cand_serial),
        .sel         (sel)
    );

    always_comb
    begin
        holding_next  = hold_upd;
        awaiting_next = await_upd;
        emit          = !any_wait;
        res_key       = '0;
        res_serial    = '0;
        res_way       = '0;
        res_done      = 1'b0;
        if (!any_wait)
        begin
            if (sel.found)
            begin
                holding_next[sel.best]  = 1'b0;
                awaiting_next[sel.best] = 1'b1;
                res_key                 = cand_key[sel.best];
                res_serial              = cand_serial[sel.best];
                res_way                 = sel.best;
            end
            else
            begin
                holding_next  = '0;
                awaiting_next = '1;
                res_done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg  <= '0;
            awaiting_reg <= '1;
        end
        else if (proc_en)
        begin
            holding_reg  <= holding_next;
            awaiting_reg <= awaiting_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && wr_rec)
        begin
            held_key_reg[way_reg]    <= key_reg;
            held_serial_reg[way_reg] <= serial_reg;
        end
    end

    kwtm_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (proc_en),
        .emit       (emit),
        .res_key    (res_key),
        .res_serial (res_serial),
        .res_way    (res_way),
        .res_done   (res_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_key    (out_key),
        .out_serial (out_serial),
        .out_way    (out_way),
        .done_res   (done_res)
    );

endmodule
